// File: rtl/pwc_pkg.sv
// Shared constants and a helper function of the parallax warp compositor.
// Depends on nothing; the compositor top level imports it.
`default_nettype none

package pwc_pkg;

	// Tile store geometry. TILE_DIM must be a power of two.
	localparam int TILE_DIM    = 64;
	localparam int TILE_AW     = $clog2(TILE_DIM);
	localparam int STORE_DEPTH = TILE_DIM * TILE_DIM;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// Stream beat widths.
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;

	// Item kinds carried in tuser.
	localparam logic [1:0] KIND_TILE_WRITE = 2'd0;
	localparam logic [1:0] KIND_ROW_START  = 2'd1;
	localparam logic [1:0] KIND_PIXEL      = 2'd2;

	// Register indexes (byte address is four times the index).
	localparam int CFG_AW = 5;
	localparam logic [2:0] REG_VIEW_TOP      = 3'd0;
	localparam logic [2:0] REG_TILE_MASK_X   = 3'd1;
	localparam logic [2:0] REG_TILE_MASK_Y   = 3'd2;
	localparam logic [2:0] REG_SCROLL_X      = 3'd3;
	localparam logic [2:0] REG_SCROLL_Y      = 3'd4;
	localparam logic [2:0] REG_WOBBLE_PHASE  = 3'd5;
	localparam logic [2:0] REG_WOBBLE_STEP   = 3'd6;
	localparam logic [2:0] REG_WOBBLE_ENABLE = 3'd7;

	// Raster wobble offsets, one full sine-like period over 32 phases.
	localparam logic [4:0] WOBBLE_TABLE [32] = '{
		5'h00, 5'h00, 5'h00, 5'h01, 5'h01, 5'h02, 5'h03, 5'h04,
		5'h06, 5'h08, 5'h0a, 5'h0c, 5'h0d, 5'h0e, 5'h0f, 5'h0f,
		5'h10, 5'h10, 5'h10, 5'h0f, 5'h0f, 5'h0e, 5'h0d, 5'h0c,
		5'h0a, 5'h08, 5'h06, 5'h04, 5'h03, 5'h02, 5'h01, 5'h01
	};

	// Flat store address of a tile line and column, both wrapped to the tile.
	function automatic logic [STORE_AW-1:0] store_addr(input logic [5:0] line,
		input logic [5:0] col);
		logic [TILE_AW-1:0] l;
		logic [TILE_AW-1:0] c;
		l = TILE_AW'(line % TILE_DIM);
		c = TILE_AW'(col % TILE_DIM);
		return STORE_AW'(l * TILE_DIM + c);
	endfunction

endpackage

`default_nettype wire

// File: rtl/parallax_warp_compositor_unit.sv
// Parallax warp compositor top level: stream ports, APB register file,
// tile store memory and the two-stage pixel pipeline. Depends on pwc_pkg.
`default_nettype none

// How the block is used.
// The input stream carries three kinds of beat, selected by s_tuser: a tile
// write loads one palette index into the 64x64 tile store, a row start latches
// the tile line, horizontal offset and screen row for the row that follows,
// and a pixel beat composites its foreground index over the tile. Only pixel
// beats produce an output beat; kind 3 is accepted and dropped.
// A pixel beat that is accepted has its synchronous tile store read captured
// in the read stage; it then loads the output register when that is free
// and is presented on m_tdata. Throughput is one beat per clock for every
// kind while the output is not stalled, since the single port of the tile
// store serves either one write or one read per cycle. A tile write followed
// directly by a pixel that reads the same entry sees the new value, since
// the write lands before the read.
// When the receiver stalls, the output register holds its beat; the read stage
// behind it still takes one more beat, and then s_tready falls until the
// output drains. Nothing is lost or repeated.
// Reset clears the registers to their documented values and empties the
// pipeline. The tile store is not cleared: load every entry that will be read.
// The user writes registers through APB only with the stream idle; unchecked.
module parallax_warp_compositor_unit
	import pwc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tile_row[5:0], tile_col[11:6], tile_value[19:12], level_x[35:20],
	// level_y[51:36], row_index[59:52], column[68:60], fg_pixel[76:69], zeros
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	// Output stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// pixel[7:0], out_row[16:8], out_column[25:17], zeros
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// Register port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_AW-1:0]     paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	// Configuration registers.
	logic [7:0] view_top_q;
	logic [5:0] tile_mask_x_q;
	logic [5:0] tile_mask_y_q;
	logic [7:0] scroll_x_q;
	logic [7:0] scroll_y_q;
	logic [7:0] wobble_phase_q;
	logic [7:0] wobble_step_q;
	logic       wobble_enable_q;

	// Row state latched at each row start.
	logic [15:0] row_offset_q;
	logic [5:0]  row_tile_line_q;
	logic [8:0]  row_screen_line_q;

	// Tile store.
	logic [7:0] tile_mem [STORE_DEPTH];

	// Unpacked input fields.
	logic [1:0]  kind;
	logic [5:0]  tile_row;
	logic [5:0]  tile_col;
	logic [7:0]  tile_value;
	logic [15:0] level_x;
	logic [15:0] level_y;
	logic [7:0]  row_index;
	logic [8:0]  column;
	logic [7:0]  fg_pixel;

	assign kind       = s_tuser[1:0];
	assign tile_row   = s_tdata[5:0];
	assign tile_col   = s_tdata[11:6];
	assign tile_value = s_tdata[19:12];
	assign level_x    = s_tdata[35:20];
	assign level_y    = s_tdata[51:36];
	assign row_index  = s_tdata[59:52];
	assign column     = s_tdata[68:60];
	assign fg_pixel   = s_tdata[76:69];

	// Pipeline registers: read stage and output stage.
	logic       valid_s1;
	logic [7:0] fg_s1;
	logic [8:0] row_s1;
	logic [8:0] col_s1;
	logic [7:0] tile_s1;
	logic       m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic out_free;
	logic accept;
	logic wr_cfg;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign pready   = 1'b1;
	assign wr_cfg   = psel && penable && pwrite && pready;

	// Register file write and read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_top_q      <= '0;
			tile_mask_x_q   <= 6'h3f;
			tile_mask_y_q   <= 6'h3f;
			scroll_x_q      <= '0;
			scroll_y_q      <= '0;
			wobble_phase_q  <= '0;
			wobble_step_q   <= '0;
			wobble_enable_q <= 1'b0;
		end else if (wr_cfg) begin
			unique case (paddr[4:2])
				REG_VIEW_TOP:      view_top_q      <= pwdata[7:0];
				REG_TILE_MASK_X:   tile_mask_x_q   <= pwdata[5:0];
				REG_TILE_MASK_Y:   tile_mask_y_q   <= pwdata[5:0];
				REG_SCROLL_X:      scroll_x_q      <= pwdata[7:0];
				REG_SCROLL_Y:      scroll_y_q      <= pwdata[7:0];
				REG_WOBBLE_PHASE:  wobble_phase_q  <= pwdata[7:0];
				REG_WOBBLE_STEP:   wobble_step_q   <= pwdata[7:0];
				REG_WOBBLE_ENABLE: wobble_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_VIEW_TOP:      prdata = {24'd0, view_top_q};
			REG_TILE_MASK_X:   prdata = {26'd0, tile_mask_x_q};
			REG_TILE_MASK_Y:   prdata = {26'd0, tile_mask_y_q};
			REG_SCROLL_X:      prdata = {24'd0, scroll_x_q};
			REG_SCROLL_Y:      prdata = {24'd0, scroll_y_q};
			REG_WOBBLE_PHASE:  prdata = {24'd0, wobble_phase_q};
			REG_WOBBLE_STEP:   prdata = {24'd0, wobble_step_q};
			REG_WOBBLE_ENABLE: prdata = {31'd0, wobble_enable_q};
			default:           prdata = '0;
		endcase
	end

	// Row start arithmetic. The level scroll is halved with an arithmetic
	// shift; only the low five bits of the wobble phase matter, so the
	// phase product is formed on five-bit operands.
	logic [15:0] half_x;
	logic [15:0] half_y;
	logic [4:0]  phase;
	logic [4:0]  wobble;
	logic [15:0] next_offset;
	logic [5:0]  next_tile_line;
	logic [8:0]  next_screen_line;

	always_comb begin
		half_x = {level_x[15], level_x[15:1]};
		half_y = {level_y[15], level_y[15:1]};
		phase  = wobble_phase_q[4:0]
			+ 5'((half_y[4:0] + row_index[4:0]) * wobble_step_q[4:0]);
		wobble = wobble_enable_q ? WOBBLE_TABLE[phase] : 5'd0;
		next_offset = half_x + {8'd0, scroll_x_q} + {11'd0, wobble};
		next_tile_line = (half_y[5:0] + scroll_y_q[5:0] + view_top_q[5:0]
			+ row_index[5:0]) & tile_mask_y_q;
		next_screen_line = {1'b0, view_top_q} + {1'b0, row_index};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_offset_q      <= '0;
			row_tile_line_q   <= '0;
			row_screen_line_q <= '0;
		end else if (accept && kind == KIND_ROW_START) begin
			row_offset_q      <= next_offset;
			row_tile_line_q   <= next_tile_line;
			row_screen_line_q <= next_screen_line;
		end
	end

	// Tile store port: a write for a tile write beat, a read for a pixel beat.
	logic [5:0]          tile_x;
	logic [STORE_AW-1:0] wr_addr;
	logic [STORE_AW-1:0] rd_addr;
	logic                mem_wr;
	logic                mem_rd;

	assign tile_x  = (column[5:0] + row_offset_q[5:0]) & tile_mask_x_q;
	assign wr_addr = store_addr(tile_row, tile_col);
	assign rd_addr = store_addr(row_tile_line_q, tile_x);
	assign mem_wr  = accept && kind == KIND_TILE_WRITE;
	assign mem_rd  = accept && kind == KIND_PIXEL;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			tile_mem[wr_addr] <= tile_value;
		end
		if (mem_rd) begin
			tile_s1 <= tile_mem[rd_addr];
		end
	end

	// Read stage: carries the pixel beat while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= mem_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd) begin
			fg_s1  <= fg_pixel;
			row_s1 <= row_screen_line_q;
			col_s1 <= column;
		end
	end

	// Output stage: transparent foreground shows the tile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_data_q <= {6'd0, col_s1, row_s1, (fg_s1 != 8'd0) ? fg_s1 : tile_s1};
		end
	end

endmodule

`default_nettype wire

// File: verif/tb_parallax_warp_compositor_unit.sv
// Self-checking testbench for parallax_warp_compositor_unit: directed and random beats on the
// input stream, APB register phases, and a scoreboard fed by an in-bench compositor predictor.
// Depends on pwc_pkg and the compositor top level.
`default_nettype none

module tb_parallax_warp_compositor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pwc_pkg::*;

	// Kind 3 is not defined; the block must swallow it without effect.
	localparam logic [1:0] KIND_IGNORED = 2'd3;
	// Quiet cycles tolerated before the run is declared hung. The longest legal
	// silence is the forced receiver hold-off plus a long sender gap.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int FRAME_BEATS    = 140;

	// Raster wobble offsets over one period of 32 phases.
	localparam logic [4:0] RASTER_SHIFT [32] = '{
		5'h00, 5'h00, 5'h00, 5'h01, 5'h01, 5'h02, 5'h03, 5'h04,
		5'h06, 5'h08, 5'h0a, 5'h0c, 5'h0d, 5'h0e, 5'h0f, 5'h0f,
		5'h10, 5'h10, 5'h10, 5'h0f, 5'h0f, 5'h0e, 5'h0d, 5'h0c,
		5'h0a, 5'h08, 5'h06, 5'h04, 5'h03, 5'h02, 5'h01, 5'h01
	};

	typedef struct {
		logic [1:0]         kind;
		logic [5:0]         trow;
		logic [5:0]         tcol;
		logic [7:0]         tval;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic [7:0]         ridx;
		logic [8:0]         col;
		logic [7:0]         fg;
	} bg_beat_t;

	typedef struct {
		logic [7:0] pixel;
		logic [8:0] row;
		logic [8:0] column;
	} screen_px_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// tile_row[5:0], tile_col[11:6], tile_value[19:12], level_x[35:20],
	// level_y[51:36], row_index[59:52], column[68:60], fg_pixel[76:69], zeros
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// kind[1:0]
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// pixel[7:0], out_row[16:8], out_column[25:17], zeros
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_AW-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	parallax_warp_compositor_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: register copies, the tile store with a record of which
	// entries hold real data, and the values latched by the last row start.
	logic [7:0]  cfg_view_top = 8'd0;
	logic [5:0]  cfg_mask_x = 6'd63;
	logic [5:0]  cfg_mask_y = 6'd63;
	logic [7:0]  cfg_scroll_x = 8'd0;
	logic [7:0]  cfg_scroll_y = 8'd0;
	logic [7:0]  cfg_wobble_phase = 8'd0;
	logic [7:0]  cfg_wobble_step = 8'd0;
	logic        cfg_warp_on = 1'b0;
	logic [7:0]  tile_mem [STORE_DEPTH];
	bit          tile_loaded [STORE_DEPTH];
	logic [15:0] line_offset = 16'd0;
	logic [5:0]  line_tile_row = 6'd0;
	logic [8:0]  line_screen_row = 9'd0;

	screen_px_t  screen_px_q [$];
	int          error_count = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          hold_request = 1'b0;

	// Gap lengths: one draw in ten comes from the long range, the others from the short one.
	function automatic int idle_span();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] reg_value(input logic [2:0] idx);
		case (idx)
			REG_VIEW_TOP:      return 32'(cfg_view_top);
			REG_TILE_MASK_X:   return 32'(cfg_mask_x);
			REG_TILE_MASK_Y:   return 32'(cfg_mask_y);
			REG_SCROLL_X:      return 32'(cfg_scroll_x);
			REG_SCROLL_Y:      return 32'(cfg_scroll_y);
			REG_WOBBLE_PHASE:  return 32'(cfg_wobble_phase);
			REG_WOBBLE_STEP:   return 32'(cfg_wobble_step);
			default:           return 32'(cfg_warp_on);
		endcase
	endfunction

	// Store address that a pixel at this column reads under the current row.
	function automatic logic [11:0] tile_addr(input logic [8:0] col);
		logic [5:0] tc;
		tc = 6'(16'(col) + line_offset) & cfg_mask_x;
		return {line_tile_row, tc};
	endfunction

	// Half-rate parallax: the level scroll is halved with its sign kept.
	function automatic void latch_row(input logic signed [15:0] lx, input logic signed [15:0] ly,
		input logic [7:0] ridx);
		logic [15:0] hx;
		logic [15:0] hy;
		logic [15:0] ofs;
		logic [4:0]  ph;
		hx = {lx[15], lx[15:1]};
		hy = {ly[15], ly[15:1]};
		ofs = hx + 16'(cfg_scroll_x);
		if (cfg_warp_on) begin
			ph = 5'(cfg_wobble_phase + hy * cfg_wobble_step + ridx * cfg_wobble_step);
			ofs = ofs + 16'(RASTER_SHIFT[ph]);
		end
		line_offset = ofs;
		line_tile_row = 6'(hy + 16'(cfg_scroll_y) + 16'(cfg_view_top) + 16'(ridx)) & cfg_mask_y;
		line_screen_row = 9'(cfg_view_top) + 9'(ridx);
	endfunction

	function automatic void apply_beat(input bg_beat_t b);
		screen_px_t px;
		logic [11:0] a;
		case (b.kind)
			KIND_TILE_WRITE: begin
				tile_mem[{b.trow, b.tcol}] = b.tval;
				tile_loaded[{b.trow, b.tcol}] = 1'b1;
			end
			KIND_ROW_START: latch_row(b.lx, b.ly, b.ridx);
			KIND_PIXEL: begin
				a = tile_addr(b.col);
				px.pixel = (b.fg != 8'd0) ? b.fg : tile_mem[a];
				px.row = line_screen_row;
				px.column = b.col;
				screen_px_q.push_back(px);
			end
			default: ;
		endcase
	endfunction

	// One beat on the input stream. Valid is either dropped for a gap or kept
	// high straight into the next beat, never both at one falling edge.
	task automatic offer_beat(input bg_beat_t b);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (idle_span() - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= b.kind;
		s_tdata <= {3'b000, b.fg, b.col, b.ridx, b.ly, b.lx, b.tval, b.tcol, b.trow};
		do @(posedge clk); while (!s_tready);
		apply_beat(b);
		if (b.kind != KIND_IGNORED)
			items_sent++;
	endtask

	task automatic send_tile(input logic [5:0] r, input logic [5:0] c, input logic [7:0] v);
		bg_beat_t b;
		b = '{kind: KIND_TILE_WRITE, trow: r, tcol: c, tval: v, default: '0};
		offer_beat(b);
	endtask

	task automatic send_row(input logic [15:0] lx, input logic [15:0] ly, input logic [7:0] ri);
		bg_beat_t b;
		b = '{kind: KIND_ROW_START, lx: lx, ly: ly, ridx: ri, default: '0};
		offer_beat(b);
	endtask

	// A transparent pixel over a never-loaded entry would read undefined data,
	// so such a pixel is given an opaque foreground instead.
	task automatic send_pixel(input logic [8:0] col, input logic [7:0] fg);
		bg_beat_t b;
		if (fg == 8'd0 && !tile_loaded[tile_addr(col)])
			fg = 8'($urandom_range(1, 255));
		b = '{kind: KIND_PIXEL, col: col, fg: fg, default: '0};
		offer_beat(b);
	endtask

	task automatic send_noise();
		bg_beat_t b;
		b = '{kind: KIND_IGNORED, trow: 6'($urandom), tcol: 6'($urandom), tval: 8'($urandom),
			lx: 16'($urandom), ly: 16'($urandom), ridx: 8'($urandom), col: 9'($urandom),
			fg: 8'($urandom)};
		offer_beat(b);
	endtask

	// Stop offering and wait until every pixel is out and the beats that make
	// no output have left the pipeline, so registers can be touched.
	task automatic drain_stream();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (screen_px_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write followed by a read-back of the same register.
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_VIEW_TOP:     cfg_view_top = value[7:0];
			REG_TILE_MASK_X:  cfg_mask_x = value[5:0];
			REG_TILE_MASK_Y:  cfg_mask_y = value[5:0];
			REG_SCROLL_X:     cfg_scroll_x = value[7:0];
			REG_SCROLL_Y:     cfg_scroll_y = value[7:0];
			REG_WOBBLE_PHASE: cfg_wobble_phase = value[7:0];
			REG_WOBBLE_STEP:  cfg_wobble_step = value[7:0];
			default:          cfg_warp_on = value[0];
		endcase
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_value(idx)) begin
			$error("register %0d read-back: expected %0h, got %0h", idx, reg_value(idx), prdata);
			error_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_all(input logic [7:0] vt, input logic [5:0] mx, input logic [5:0] my,
		input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] ph, input logic [7:0] st,
		input logic en);
		cfg_write(REG_VIEW_TOP, 32'(vt));
		cfg_write(REG_TILE_MASK_X, 32'(mx));
		cfg_write(REG_TILE_MASK_Y, 32'(my));
		cfg_write(REG_SCROLL_X, 32'(sx));
		cfg_write(REG_SCROLL_Y, 32'(sy));
		cfg_write(REG_WOBBLE_PHASE, 32'(ph));
		cfg_write(REG_WOBBLE_STEP, 32'(st));
		cfg_write(REG_WOBBLE_ENABLE, 32'(en));
	endtask

	// Reset row values are all zero, so pixels before any row start read tile
	// line 0 at their own column. An undefined kind in between must not disturb.
	task automatic test_reset_row_state();
		send_tile(6'd0, 6'd0, 8'h5a);
		send_tile(6'd0, 6'd63, 8'hff);
		send_tile(6'd63, 6'd0, 8'h00);
		send_tile(6'd63, 6'd63, 8'h81);
		send_pixel(9'd0, 8'd0);
		send_pixel(9'd511, 8'd0);
		send_pixel(9'd300, 8'hff);
		send_noise();
		send_pixel(9'd0, 8'd0);
	endtask

	// Every register but the two tile masks at its top value, warp on, and the level scroll
	// at the ends of its signed range. The 2x2 tile keeps every transparent pixel on loaded data.
	task automatic test_field_extremes();
		drain_stream();
		program_all(8'd255, 6'd1, 6'd1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_tile(6'd0, 6'd1, 8'h01);
		send_tile(6'd1, 6'd0, 8'h80);
		send_tile(6'd1, 6'd1, 8'h7e);
		send_row(16'h8000, 16'h7fff, 8'd255);
		send_pixel(9'd0, 8'd0);
		send_pixel(9'd511, 8'd0);
		send_row(16'h7fff, 16'h8000, 8'd0);
		send_pixel(9'd1, 8'd0);
		send_pixel(9'd256, 8'd1);
		send_row(16'hffff, 16'hffff, 8'd128);
		send_pixel(9'd2, 8'd0);
		send_pixel(9'd3, 8'd0);
		send_row(16'h0000, 16'h0000, 8'd0);
		send_pixel(9'd511, 8'd0);
		send_pixel(9'd100, 8'd0);
	endtask

	// The receiver stops for a long stretch while the sender keeps offering a row
	// of pixels, so the output fills and the input has to stall.
	task automatic test_output_backpressure();
		drain_stream();
		tx_idle_pct = 0;
		hold_request = 1'b1;
		send_row(16'($urandom), 16'($urandom), 8'($urandom));
		for (int i = 0; i < 40; i++)
			send_pixel(9'(i), ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom));
	endtask

	function automatic logic [5:0] pick_mask();
		if ($urandom_range(0, 1) != 0)
			return 6'($urandom);
		return 6'((1 << $urandom_range(0, 6)) - 1);
	endfunction

	function automatic logic [15:0] pick_scroll();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'(int'($urandom_range(0, 7)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Several register settings, each followed by a tile load (every entry the masks can
	// reach when they are narrow, else random entries) and a frame of row starts and pixel runs.
	task automatic test_random_frames();
		int first;
		int r;
		logic [8:0] col;
		logic [5:0] mx;
		logic [5:0] my;
		for (int p = 0; p < 8; p++) begin
			drain_stream();
			if (p == 0)
				program_all(8'd255, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
			else if (p == 1)
				program_all(8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
			else
				program_all(8'($urandom), pick_mask(), pick_mask(), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 1'($urandom));
			tx_idle_pct = (p % 3 == 0) ? 0 : 25;
			rx_stall_pct = (p % 4 == 1) ? 0 : 20;
			mx = cfg_mask_x;
			my = cfg_mask_y;
			if ($countones(mx) + $countones(my) <= 6) begin
				for (int a = 0; a < STORE_DEPTH; a++)
					if ((6'(a >> 6) & ~my) == 6'd0 && (6'(a) & ~mx) == 6'd0)
						send_tile(6'(a >> 6), 6'(a), 8'($urandom));
			end else begin
				repeat (40)
					send_tile(6'($urandom) & my, 6'($urandom) & mx, 8'($urandom));
			end
			first = items_sent;
			while (items_sent - first < FRAME_BEATS) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					send_tile(6'($urandom), 6'($urandom), 8'($urandom));
				else if (r < 10)
					send_noise();
				else if (r < 14)
					send_pixel(9'($urandom), 8'($urandom));
				else begin
					send_row(pick_scroll(), pick_scroll(), 8'($urandom));
					col = 9'($urandom);
					repeat ($urandom_range(1, 24)) begin
						send_pixel(col, ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom));
						col = ($urandom_range(0, 7) == 0) ? 9'($urandom) : col + 9'd1;
					end
				end
			end
		end
	endtask

	// Receiver: ready most of the time, with random stalls while enabled and one
	// long forced hold-off on request. One assignment per falling edge.
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if ($urandom_range(0, 99) < rx_stall_pct) begin
				m_tready <= 1'b0;
				repeat (idle_span() - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each output beat is matched against the oldest pending pixel.
	always @(posedge clk) begin
		screen_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (screen_px_q.size() == 0) begin
				$error("output beat with nothing pending: %h", m_tdata);
				error_count++;
			end else begin
				want = screen_px_q.pop_front();
				if (m_tdata[7:0] !== want.pixel) begin
					$error("pixel: expected %0d, got %0d", want.pixel, m_tdata[7:0]);
					error_count++;
				end
				if (m_tdata[16:8] !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, m_tdata[16:8]);
					error_count++;
				end
				if (m_tdata[25:17] !== want.column) begin
					$error("out_column: expected %0d, got %0d", want.column, m_tdata[25:17]);
					error_count++;
				end
			end
		end
	end

	// Hang detector: any accepted beat or register transfer restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("parallax_warp_compositor_unit verification failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		for (int a = 0; a < STORE_DEPTH; a++)
			tile_loaded[a] = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		rx_stall_pct = 20;
		tx_idle_pct = 25;
		test_reset_row_state();
		test_field_extremes();
		test_output_backpressure();
		test_random_frames();
		drain_stream();
		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("parallax_warp_compositor_unit verification clean");
		else
			$display("parallax_warp_compositor_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
